// ===== rtl/core/segmented_odd_prime_sieve_top_assert.svh =====
// Assertion macros for the segmented odd prime sieve.
// Used by the checker; needs nothing else.
`ifndef SEGMENTED_ODD_PRIME_SIEVE_TOP_ASSERT_SVH
`define SEGMENTED_ODD_PRIME_SIEVE_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is low.
`define SOPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sops assertion failed");

// Clocked assertion that also holds during reset.
`define SOPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("sops assertion failed");

`endif

// ===== rtl/core/sops_pkg.sv =====
// Package for the segmented odd prime sieve: payload, config and
// controller/datapath interface types. No dependencies.
package sops_pkg;

  localparam int unsigned StartW   = 30;
  localparam int unsigned SizeW    = 13;
  localparam int unsigned PrimeW   = 16;
  localparam int unsigned CountW   = 13;
  localparam int unsigned CandW    = 31;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 30;
  localparam int unsigned ValW     = 32;
  localparam int unsigned FirstW   = 33;

  localparam logic [CfgIdxW-1:0] CFG_START = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SIZE  = 1'b1;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_MARK  = 1'b1;

  localparam logic [SizeW-1:0] SizeReset = 13'd4096;

  typedef struct packed {
    logic              cmd;
    logic [PrimeW-1:0] sieving_prime;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0] unmarked_count;
    logic [CandW-1:0]  next_candidate;
    logic              candidate_found;
  } out_t;

  typedef struct packed {
    logic load;
    logic clr_en;
    logic idx_clr;
    logic div_start;
    logic div_en;
    logic first_en;
    logic odd_en;
    logic j_en;
    logic mark_en;
    logic scan_en;
    logic result_en;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_clear;
    logic skip_mark;
    logic pp_ge_low;
    logic div_done;
    logic mark_done;
    logic scan_done;
  } dp_status_t;

endpackage

// ===== rtl/core/sops_datapath.sv =====
// Datapath of the segmented odd prime sieve: config registers, bitmap
// memory, remainder divider, mark stride and scan counters, result register.
// Depends on sops_pkg.
module sops_datapath #(
  parameter int unsigned SEGMENT_DEPTH = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sops_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sops_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  sops_pkg::in_t                      in_data_i,
  input  sops_pkg::dp_cmd_t                  cmd_i,
  output sops_pkg::dp_status_t               status_o,
  output sops_pkg::out_t                     out_data_o
);

  localparam int unsigned AW = $clog2(SEGMENT_DEPTH);
  localparam int unsigned NW = $clog2(SEGMENT_DEPTH + 1);
  localparam int unsigned VW = sops_pkg::ValW;
  localparam int unsigned FW = sops_pkg::FirstW;
  localparam int unsigned PW = sops_pkg::PrimeW;

  logic [sops_pkg::StartW-1:0] start_q;
  logic [sops_pkg::SizeW-1:0]  size_q;

  logic          cmd_q;
  logic [PW-1:0] p_q;
  logic [PW-1:0] thr_q;
  logic [NW-1:0] n_q;
  logic [VW-1:0] low_q;
  logic [VW-1:0] pp_q;

  logic [VW-1:0] dvd_q;
  logic [PW:0]   rem_q;
  logic [4:0]    dcnt_q;
  logic [PW:0]   rem_t;

  logic [FW-1:0] first_q;
  logic [FW-1:0] j_q;
  logic [NW-1:0] idx_q;
  logic          rv_q;
  logic [NW-1:0] rk_q;
  logic          rd_q;
  logic [NW-1:0] count_q;
  logic          found_q;
  logic [sops_pkg::CandW-1:0] cand_q;
  sops_pkg::out_t out_q;

  logic          mem_q [SEGMENT_DEPTH];
  logic          we;
  logic [AW-1:0] wa;
  logic          issue;
  logic [VW-1:0] scan_val;
  logic [NW-1:0] n_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      size_q  <= sops_pkg::SizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sops_pkg::CFG_START: start_q <= cfg_wdata_i[sops_pkg::StartW-1:0];
        sops_pkg::CFG_SIZE:  size_q  <= cfg_wdata_i[sops_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the size to the bitmap depth.
  always_comb begin
    if (32'(size_q) > 32'(SEGMENT_DEPTH)) begin
      n_d = NW'(SEGMENT_DEPTH);
    end else begin
      n_d = NW'(size_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_data_i.cmd;
      p_q   <= in_data_i.sieving_prime;
      thr_q <= (in_data_i.cmd == sops_pkg::CMD_MARK) ? in_data_i.sieving_prime : '0;
      n_q   <= n_d;
      low_q <= {1'b0, start_q, 1'b0} + VW'(3);
      pp_q  <= VW'(in_data_i.sieving_prime) * VW'(in_data_i.sieving_prime);
    end
  end

  // Restoring divider, one quotient bit a cycle, keeps low mod p.
  assign rem_t = {rem_q[PW-1:0], dvd_q[VW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q  <= low_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_en) begin
      dvd_q  <= {dvd_q[VW-2:0], 1'b0};
      dcnt_q <= dcnt_q + 5'd1;
      if (rem_t >= {1'b0, p_q}) begin
        rem_q <= rem_t - {1'b0, p_q};
      end else begin
        rem_q <= rem_t;
      end
    end
  end

  // First odd multiple at or above the low value, then its bitmap index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.first_en) begin
      if (status_o.pp_ge_low) begin
        first_q <= FW'(pp_q);
      end else if (rem_q == '0) begin
        first_q <= FW'(low_q);
      end else begin
        first_q <= FW'(low_q) + FW'(p_q) - FW'(rem_q);
      end
    end else if (cmd_i.odd_en) begin
      if (!first_q[0]) begin
        first_q <= first_q + FW'(p_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.j_en) begin
      j_q <= ((first_q - FW'(3)) >> 1) - FW'(start_q);
    end else if (cmd_i.mark_en && !status_o.mark_done) begin
      j_q <= j_q + FW'(p_q);
    end
  end

  // Bitmap memory: one write port for clear and mark, one registered read.
  assign we = cmd_i.clr_en || (cmd_i.mark_en && !status_o.mark_done);
  assign wa = cmd_i.clr_en ? idx_q[AW-1:0] : j_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= !cmd_i.clr_en;
    end
    rd_q <= mem_q[idx_q[AW-1:0]];
  end

  assign issue = cmd_i.scan_en && (idx_q < n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      rv_q <= issue;
      if (cmd_i.load || cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.clr_en || issue) begin
        idx_q <= idx_q + NW'(1);
      end
    end
  end

  assign scan_val = {1'b0, start_q, 1'b0} + VW'({rk_q, 1'b0}) + VW'(3);

  always_ff @(posedge clk_i) begin
    rk_q <= idx_q;
    if (cmd_i.load) begin
      count_q <= '0;
      found_q <= 1'b0;
      cand_q  <= '0;
    end else if (rv_q && !rd_q) begin
      count_q <= count_q + NW'(1);
      if (!found_q && (scan_val > VW'(thr_q))) begin
        found_q <= 1'b1;
        cand_q  <= scan_val[sops_pkg::CandW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_en) begin
      out_q.unmarked_count  <= sops_pkg::CountW'(count_q);
      out_q.next_candidate  <= cand_q;
      out_q.candidate_found <= found_q;
    end
  end

  assign out_data_o = out_q;

  always_comb begin
    status_o.clr_last  = (idx_q == NW'(SEGMENT_DEPTH - 1));
    status_o.is_clear  = (cmd_q == sops_pkg::CMD_CLEAR);
    status_o.skip_mark = (n_q == '0) || !p_q[0];
    status_o.pp_ge_low = (pp_q >= low_q);
    status_o.div_done  = (dcnt_q == 5'd31);
    status_o.mark_done = (j_q >= FW'(n_q));
    status_o.scan_done = !issue && !rv_q;
  end

endmodule

// ===== rtl/core/sops_ctrl.sv =====
// Controller of the segmented odd prime sieve: sequences clear, divide,
// mark and scan, and owns the handshakes. Depends on sops_pkg.
module sops_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  sops_pkg::dp_status_t status_i,
  output sops_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    ST_INIT   = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_CLEAR  = 11'b000_0000_0100,
    ST_CHECK  = 11'b000_0000_1000,
    ST_DIVIDE = 11'b000_0001_0000,
    ST_FIRST  = 11'b000_0010_0000,
    ST_ODDFIX = 11'b000_0100_0000,
    ST_JCALC  = 11'b000_1000_0000,
    ST_MARK   = 11'b001_0000_0000,
    ST_SCAN   = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status_i.is_clear) begin
          state_d = ST_CLEAR;
        end else if (status_i.skip_mark) begin
          state_d = ST_SCAN;
        end else if (status_i.pp_ge_low) begin
          state_d = ST_FIRST;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVIDE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_en = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd_o.first_en = 1'b1;
        state_d        = ST_ODDFIX;
      end
      ST_ODDFIX: begin
        cmd_o.odd_en = 1'b1;
        state_d      = ST_JCALC;
      end
      ST_JCALC: begin
        cmd_o.j_en = 1'b1;
        state_d    = ST_MARK;
      end
      ST_MARK: begin
        cmd_o.mark_en = 1'b1;
        if (status_i.mark_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (out_free) begin
          cmd_o.result_en = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.result_en) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/segmented_odd_prime_sieve_top.sv =====
// Segmented odd-only sieve of Eratosthenes.
// Request channel: in_valid_i / in_stall_o carry in_data_i (cmd, sieving_prime).
// Result channel: out_valid_o / out_stall_i carry out_data_o, one result per request.
// Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 start index,
// 1 segment size); write only while the block is idle.
// A clear request sweeps all SEGMENT_DEPTH bitmap entries, one per cycle, then
// scans the n active entries.
// A mark request runs the remainder divider when p*p lies below the segment,
// then marks every p-th entry from the first odd multiple, then scans the n
// entries. The single bitmap memory port pair sets the pace.
// One request is worked at a time; the next is taken once the result sits in
// the output register, even if the receiver still stalls it.
// After reset a clearing pass over all SEGMENT_DEPTH entries runs with in_stall_o
// high; config writes are taken meanwhile.
// A stalled result holds in the output register; the block finishes the next
// request and then waits for the register to empty.
// Depends on sops_pkg, sops_ctrl and sops_datapath.
module segmented_odd_prime_sieve_top #(
  parameter int unsigned SEGMENT_DEPTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sops_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sops_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sops_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sops_pkg::out_t                out_data_o
);

  sops_pkg::dp_cmd_t    dp_cmd;
  sops_pkg::dp_status_t dp_status;

  sops_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  sops_datapath #(
    .SEGMENT_DEPTH(SEGMENT_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/sops_checker.sv =====
// Port checker for the segmented odd prime sieve, bound to the top level.
// Depends on sops_pkg and segmented_odd_prime_sieve_top_assert.svh.
`include "segmented_odd_prime_sieve_top_assert.svh"

module sops_checker #(
  parameter int unsigned SEGMENT_DEPTH = 4096
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input sops_pkg::out_t out_data_o
);

  `SOPS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  `SOPS_ASSERT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  `SOPS_ASSERT(a_no_cand_zero, clk_i, rst_ni, out_valid_o && !out_data_o.candidate_found |-> out_data_o.next_candidate == '0)
  `SOPS_ASSERT(a_count_range, clk_i, rst_ni, out_valid_o |-> 32'(out_data_o.unmarked_count) <= 32'(SEGMENT_DEPTH))
  `SOPS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o && in_stall_o)

endmodule

bind segmented_odd_prime_sieve_top sops_checker #(
  .SEGMENT_DEPTH(SEGMENT_DEPTH)
) u_sops_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
